/* rtl/sid_pkg.sv */
// Shared types and constants for the signed integer divider.
// No dependencies; every other rtl file refers to this package by scoped names.
package sid_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int STATUS_W      = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = STATUS_W'(0),
        ST_OVF  = STATUS_W'(1),
        ST_DIV0 = STATUS_W'(2)
    } t_status;

    localparam logic [OPERAND_WIDTH-1:0] MIN_VAL  = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
    localparam logic [OPERAND_WIDTH-1:0] MAX_VAL  = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
    localparam logic [OPERAND_WIDTH-1:0] ALL_ONES = {OPERAND_WIDTH{1'b1}};

    // One pipeline slot of the long division.
    // nq holds the remaining dividend bits at the top and the quotient bits
    // shifted in from the bottom.
    typedef struct packed {
        logic [OPERAND_WIDTH-1:0] rem;
        logic [OPERAND_WIDTH-1:0] nq;
        logic [OPERAND_WIDTH-1:0] dm;
        logic                     neg;
        t_status                  status;
    } t_stage;

endpackage

/* rtl/sid_in_if.sv */
// Request channel of the divider: dividend and divisor beats.
// Depends on sid_pkg for the operand width.
interface sid_in_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [sid_pkg::OPERAND_WIDTH-1:0]  numerator;
    logic signed [sid_pkg::OPERAND_WIDTH-1:0]  denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

/* rtl/sid_out_if.sv */
// Response channel of the divider: quotient and status beats.
// Depends on sid_pkg for the operand and status widths.
interface sid_out_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [sid_pkg::OPERAND_WIDTH-1:0]  quotient;
    logic        [sid_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output quotient, output status, input ready);
    modport sink   (input valid, input quotient, input status, output ready);
endinterface

/* rtl/sid_prep.sv */
// Entry stage: special case detection, operand magnitudes and result sign.
// Depends on sid_pkg.
module sid_prep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [sid_pkg::OPERAND_WIDTH-1:0] i_num,
    input  logic [sid_pkg::OPERAND_WIDTH-1:0] i_den,
    output logic                              o_valid,
    output sid_pkg::t_stage                   o_data
);
    logic            r_valid;
    sid_pkg::t_stage r_data;
    sid_pkg::t_stage n_data;
    logic            nneg;
    logic            dneg;

    always_comb begin
        nneg          = i_num[sid_pkg::OPERAND_WIDTH-1];
        dneg          = i_den[sid_pkg::OPERAND_WIDTH-1];
        n_data.rem    = '0;
        // negating the most negative value yields its own pattern, which is
        // the correct magnitude read unsigned
        n_data.nq     = nneg ? (~i_num + 1'b1) : i_num;
        n_data.dm     = dneg ? (~i_den + 1'b1) : i_den;
        n_data.neg    = nneg ^ dneg;
        if (i_den == '0) begin
            n_data.status = sid_pkg::ST_DIV0;
        end else if (i_num == sid_pkg::MIN_VAL && i_den == sid_pkg::ALL_ONES) begin
            n_data.status = sid_pkg::ST_OVF;
        end else begin
            n_data.status = sid_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

/* rtl/sid_step.sv */
// One restoring division step: shift in a dividend bit, trial subtract,
// shift the resulting quotient bit into nq. Depends on sid_pkg.
module sid_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sid_pkg::t_stage i_data,
    output logic            o_valid,
    output sid_pkg::t_stage o_data
);
    logic                            r_valid;
    sid_pkg::t_stage                 r_data;
    sid_pkg::t_stage                 n_data;
    logic [sid_pkg::OPERAND_WIDTH-1:0] shifted;
    logic [sid_pkg::OPERAND_WIDTH:0]   diff;
    logic                              ge;

    // rem stays below the divisor magnitude, so the shifted value fits
    always_comb begin
        shifted = {i_data.rem[sid_pkg::OPERAND_WIDTH-2:0],
                   i_data.nq[sid_pkg::OPERAND_WIDTH-1]};
        diff    = {1'b0, shifted} - {1'b0, i_data.dm};
        ge      = ~diff[sid_pkg::OPERAND_WIDTH];
        n_data        = i_data;
        n_data.rem    = ge ? diff[sid_pkg::OPERAND_WIDTH-1:0] : shifted;
        n_data.nq     = {i_data.nq[sid_pkg::OPERAND_WIDTH-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

/* rtl/sid_fix.sv */
// Final stage: applies the quotient sign and the special case overrides,
// and holds the response register. Depends on sid_pkg.
module sid_fix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  sid_pkg::t_stage                   i_data,
    output logic                              o_valid,
    output logic [sid_pkg::OPERAND_WIDTH-1:0] o_quotient,
    output sid_pkg::t_status                  o_status
);
    logic                              r_valid;
    logic [sid_pkg::OPERAND_WIDTH-1:0] r_quot;
    sid_pkg::t_status                  r_status;
    logic [sid_pkg::OPERAND_WIDTH-1:0] n_quot;

    always_comb begin
        case (i_data.status)
            sid_pkg::ST_DIV0: n_quot = '0;
            sid_pkg::ST_OVF:  n_quot = sid_pkg::MAX_VAL;
            default:          n_quot = i_data.neg ? (~i_data.nq + 1'b1) : i_data.nq;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot   <= n_quot;
            r_status <= i_data.status;
        end
    end

    assign o_valid    = r_valid;
    assign o_quotient = r_quot;
    assign o_status   = r_status;
endmodule

/* rtl/signed_int32_divider.sv */
// Signed integer divider, quotient truncated toward zero, fully pipelined.
// Depends on sid_pkg, sid_in_if, sid_out_if, sid_prep, sid_step and sid_fix.
//
//  channel | dir | fields                    | notes
//  i_req   | in  | numerator, denominator    | valid/ready, two's complement
//  o_rsp   | out | quotient, status          | valid/ready, registered
//
// The pipe holds one entry stage, one stage per quotient bit and one sign
// fix-up stage that is also the output register.
// A new beat is taken every cycle while the response side keeps up.
// The whole pipe advances on one enable; a stalled response freezes every stage.
// Bubbles ahead of the output are not squeezed out. Synchronous reset clears
// the valid bits only.
module signed_int32_divider (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sid_in_if.sink    i_req,
    sid_out_if.source o_rsp
);
    localparam int W = sid_pkg::OPERAND_WIDTH;

    logic                w_en;
    logic [W:0]          w_valid;
    sid_pkg::t_stage     w_stage [0:W];
    sid_pkg::t_status    w_status;

    assign w_en        = ~o_rsp.valid | o_rsp.ready;
    assign i_req.ready = w_en;

    sid_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_req.valid),
        .i_num   (i_req.numerator),
        .i_den   (i_req.denominator),
        .o_valid (w_valid[0]),
        .o_data  (w_stage[0])
    );

    for (genvar k = 0; k < W; k++) begin : g_step
        sid_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_data  (w_stage[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_stage[k+1])
        );
    end

    sid_fix u_fix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_valid[W]),
        .i_data     (w_stage[W]),
        .o_valid    (o_rsp.valid),
        .o_quotient (o_rsp.quotient),
        .o_status   (w_status)
    );

    assign o_rsp.status = w_status;

    // an accepted beat lands in the entry stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> w_valid[0])
        else $error("accepted beat did not enter the pipe");

    // a stalled response freezes the last division stage too
    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> $stable(w_valid[W]))
        else $error("pipe moved during a response stall");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == sid_pkg::ST_DIV0) |-> o_rsp.quotient == '0)
        else $error("divide by zero with nonzero quotient");

    a_ovf_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == sid_pkg::ST_OVF) |-> o_rsp.quotient == sid_pkg::MAX_VAL)
        else $error("overflow without saturated quotient");

    // the largest divisor magnitude leaves a quotient of at most one
    a_ok_div_by_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[W] && w_stage[W].status == sid_pkg::ST_OK && w_stage[W].dm == sid_pkg::MIN_VAL)
        |-> w_stage[W].nq[W-1:1] == '0)
        else $error("quotient too large for divisor magnitude");
endmodule

/* tb/signed_int32_divider_tb.sv */
// Self-checking testbench for signed_int32_divider: random and corner-case divisions
// over valid/ready channels with varied idle/stall pressure. Depends on sid_pkg,
// sid_in_if, sid_out_if and the divider RTL.
`timescale 1ns / 1ps

module signed_int32_divider_tb;

    localparam int W              = sid_pkg::OPERAND_WIDTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 2 * (sid_pkg::OPERAND_WIDTH + 2);
    localparam int PHASE_ITEMS    = 285;

    typedef logic [W-1:0] t_word;

    typedef struct packed {
        t_word num;
        t_word den;
    } t_div_req;

    typedef struct packed {
        t_word            quotient;
        sid_pkg::t_status status;
    } t_div_result;

    logic i_clk;
    logic i_rst_n;

    sid_in_if  req_if ();
    sid_out_if rsp_if ();

    signed_int32_divider u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_div_req    pending_reqs[$];
    t_div_result expected_quots[$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatch_cnt   = 0;
    int          quiet_cycles   = 0;
    logic        req_taken      = 1'b0;

    // Restoring long division on magnitudes, sign applied afterwards.
    function automatic t_div_result div_predict(t_word num, t_word den);
        t_div_result res;
        t_word       n_mag;
        t_word       d_mag;
        t_word       q;
        logic [W:0]  trial;
        int          i;
        res.quotient = '0;
        res.status   = sid_pkg::ST_OK;
        if (den == '0) begin
            res.status = sid_pkg::ST_DIV0;
            return res;
        end
        if (num == sid_pkg::MIN_VAL && den == sid_pkg::ALL_ONES) begin
            res.quotient = sid_pkg::MAX_VAL;
            res.status   = sid_pkg::ST_OVF;
            return res;
        end
        n_mag = num[W-1] ? -num : num;
        d_mag = den[W-1] ? -den : den;
        q     = '0;
        trial = '0;
        for (i = W - 1; i >= 0; i--) begin
            trial = {trial[W-1:0], n_mag[i]};
            if (trial >= {1'b0, d_mag}) begin
                trial = trial - {1'b0, d_mag};
                q[i]  = 1'b1;
            end
        end
        res.quotient = (num[W-1] ^ den[W-1]) ? -q : q;
        return res;
    endfunction

    function automatic t_word corner_value();
        case ($urandom_range(0, 7))
            0:       return sid_pkg::MIN_VAL;
            1:       return sid_pkg::MAX_VAL;
            2:       return '0;
            3:       return t_word'(1);
            4:       return sid_pkg::ALL_ONES;
            5:       return sid_pkg::MIN_VAL + t_word'(1);
            6:       return t_word'(-1073741824);
            default: return sid_pkg::MAX_VAL - t_word'(1);
        endcase
    endfunction

    function automatic t_word small_signed();
        return t_word'(int'($urandom_range(0, 40)) - 20);
    endfunction

    function automatic t_div_req rand_req();
        t_div_req    r;
        int unsigned sel;
        sel   = $urandom_range(0, 99);
        r.num = $urandom;
        r.den = $urandom;
        if (sel < 20) begin
            r.num = small_signed();
            r.den = small_signed();
        end else if (sel < 35) begin
            r.den = small_signed();
        end else if (sel < 47) begin
            // spread divisor magnitudes so quotients of every length show up
            r.den = t_word'($signed(r.den) >>> $urandom_range(0, W - 1));
        end else if (sel < 55) begin
            r.num = t_word'($signed(r.num) >>> $urandom_range(0, W - 1));
        end else if (sel < 65) begin
            r.num = corner_value();
            if ($urandom_range(0, 1)) r.den = corner_value();
        end else if (sel < 70) begin
            r.den = '0;
        end else if (sel < 74) begin
            r.num = sid_pkg::MIN_VAL;
            r.den = sid_pkg::ALL_ONES;
        end
        return r;
    endfunction

    task automatic queue_req(t_word num, t_word den);
        t_div_req r;
        r.num = num;
        r.den = den;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_if.valid || expected_quots.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) pending_reqs.push_back(rand_req());
        while (pending_reqs.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.numerator   = '0;
        req_if.denominator = '0;
        rsp_if.ready       = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: sign combinations, extremes, zero divisor, overflow
        queue_req(0, 1);
        queue_req(sid_pkg::MAX_VAL, 1);
        queue_req(sid_pkg::MIN_VAL, 1);
        queue_req(sid_pkg::MIN_VAL, sid_pkg::ALL_ONES);
        queue_req(sid_pkg::MIN_VAL, 0);
        queue_req(0, 0);
        queue_req(5, 0);
        queue_req(sid_pkg::MAX_VAL, sid_pkg::ALL_ONES);
        queue_req(sid_pkg::MIN_VAL, sid_pkg::MIN_VAL);
        queue_req(sid_pkg::MAX_VAL, sid_pkg::MAX_VAL);
        queue_req(sid_pkg::MIN_VAL, sid_pkg::MAX_VAL);
        queue_req(sid_pkg::MAX_VAL, sid_pkg::MIN_VAL);
        queue_req(sid_pkg::ALL_ONES, sid_pkg::MIN_VAL);
        queue_req(1, sid_pkg::ALL_ONES);
        queue_req(-7, 2);
        queue_req(7, -2);
        queue_req(-7, -2);
        queue_req(7, 2);
        queue_req(100, 7);
        queue_req(sid_pkg::MIN_VAL, 2);
        queue_req(sid_pkg::MIN_VAL, -2);
        queue_req(-1073741824, sid_pkg::ALL_ONES);
        queue_req(3, 10);
        wait_drained();

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(83, 0, PHASE_ITEMS);
        // sender holds off until the pipe is empty
        wait_drained();
        run_phase(0, 83, PHASE_ITEMS);
        run_phase(38, 38, PHASE_ITEMS);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Driver: hold a beat until it is taken, then maybe idle, then send the next.
    always @(negedge i_clk) begin
        t_div_req nxt;
        logic     send;
        send = req_if.valid && !req_taken;
        if (!send && i_rst_n && pending_reqs.size() != 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
            nxt                 = pending_reqs.pop_front();
            send                = 1'b1;
            req_if.numerator   <= nxt.num;
            req_if.denominator <= nxt.den;
        end
        req_if.valid <= send;
        rsp_if.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: predict on request beats, check on response beats.
    always @(posedge i_clk) begin
        t_div_result want;
        logic        req_fire;
        logic        rsp_fire;
        req_fire   = req_if.valid && req_if.ready;
        rsp_fire   = rsp_if.valid && rsp_if.ready;
        req_taken <= req_fire;
        if (i_rst_n) begin
            if (req_fire)
                expected_quots.push_back(div_predict(req_if.numerator, req_if.denominator));
            if (rsp_fire) begin
                if (expected_quots.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected beat: expected none, got quotient %0d status %0d",
                             $time, rsp_if.quotient, rsp_if.status);
                end else begin
                    want = expected_quots.pop_front();
                    if (rsp_if.quotient !== want.quotient) begin
                        mismatch_cnt++;
                        $display("%0t: quotient: expected %0d, got %0d",
                                 $time, $signed(want.quotient), rsp_if.quotient);
                    end
                    if (rsp_if.status !== want.status) begin
                        mismatch_cnt++;
                        $display("%0t: status: expected %0d, got %0d",
                                 $time, want.status, rsp_if.status);
                    end
                end
            end
            quiet_cycles <= (req_fire || rsp_fire) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, expected_quots.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
